@@ hw/rtl/chd_pkg.sv @@
// Shared types, widths and codes for the canonical Huffman bit decoder.
// Used by the channel interfaces, the decoder top level and its checker.
// Depends on nothing else.

package chd_pkg;

   localparam int MAX_CODE_BITS = 16;
   localparam int SYMBOL_COUNT  = 256;

   localparam int CODE_W  = MAX_CODE_BITS;
   localparam int FIRST_W = MAX_CODE_BITS + 1;
   localparam int LEN_W   = $clog2(MAX_CODE_BITS + 1);
   localparam int IDX_W   = $clog2(SYMBOL_COUNT);
   localparam int SYM_W   = 8;
   localparam int ADDR_W  = 8;
   localparam int VAL_W   = 9;
   localparam int CNT_W   = 9;
   localparam int CFG_W   = 5;

   typedef enum logic [1:0] {
      REQ_LOAD_COUNT  = 2'd0,
      REQ_LOAD_SYMBOL = 2'd1,
      REQ_BIT         = 2'd2,
      REQ_END         = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_SYMBOL   = 2'd0,
      STATUS_CLEAN    = 2'd1,
      STATUS_LEFTOVER = 2'd2,
      STATUS_OVERLONG = 2'd3
   } status_code_type;

   localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(MAX_CODE_BITS);

endpackage

@@ hw/rtl/chd_if.sv @@
// Valid/ready channel interfaces of the canonical Huffman bit decoder:
// request, response and configuration write channels.
// Depends on chd_pkg.

interface chd_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 req_type;
   logic [chd_pkg::ADDR_W-1:0] table_addr;
   logic [chd_pkg::VAL_W-1:0]  table_value;
   logic                       bit_in;

   modport source (output valid, output req_type, output table_addr,
                   output table_value, output bit_in, input ready);
   modport sink   (input valid, input req_type, input table_addr,
                   input table_value, input bit_in, output ready);
endinterface

interface chd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [chd_pkg::SYM_W-1:0] symbol;
   logic [1:0]                status;

   modport source (output valid, output symbol, output status, input ready);
   modport sink   (input valid, input symbol, input status, output ready);
endinterface

interface chd_csr_if;
   logic                      valid;
   logic                      ready;
   logic [chd_pkg::CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/canonical_huffman_bit_decoder_top.sv @@
// Canonical Huffman bit decoder top level: tables, decode state and result register.
// Depends on chd_pkg and the channel interfaces in chd_if.sv.

// The decoder takes one request per clock cycle. Count and symbol loads fill the
// tables and give no response; each coded bit advances the code search by one length,
// and the bit that completes a code, runs past the maximum length, or an end-of-stream
// request gives one response in the cycle after its transfer. A symbol is read from
// the 256-entry symbol memory by a registered read, addressed in the cycle the
// bit is transferred. While a response waits, requests that give no response are still
// taken; a request that gives one waits for the response slot to drain or be taken in
// the same cycle. The symbol memory is not cleared after reset, so only written
// entries may be decoded. The configuration write is taken at any time outside reset.

module canonical_huffman_bit_decoder_top (
   input logic       clock,
   input logic       reset,
   chd_req_if.sink   req_bus,
   chd_rsp_if.source rsp_bus,
   chd_csr_if.sink   csr_bus
);

   logic [chd_pkg::CFG_W-1:0]   max_len_ff;
   logic [chd_pkg::CNT_W-1:0]   count_table_ff [chd_pkg::MAX_CODE_BITS+1];
   logic [chd_pkg::SYM_W-1:0]   symbol_mem_ff  [chd_pkg::SYMBOL_COUNT];
   logic [chd_pkg::CODE_W-1:0]  partial_ff;
   logic [chd_pkg::FIRST_W-1:0] first_ff;
   logic [chd_pkg::IDX_W-1:0]   base_ff;
   logic [chd_pkg::LEN_W-1:0]   taken_ff;

   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff;
   logic                        rsp_is_sym_ff;
   logic [chd_pkg::SYM_W-1:0]   sym_rd_ff;

   logic [chd_pkg::CODE_W-1:0]  partial_in;
   logic [chd_pkg::FIRST_W-1:0] first_in;
   logic [chd_pkg::IDX_W-1:0]   base_in;
   logic [chd_pkg::LEN_W-1:0]   taken_in;

   logic [chd_pkg::CFG_W-1:0]   limit;
   logic [chd_pkg::LEN_W-1:0]   len;
   logic [chd_pkg::CNT_W-1:0]   cnt;
   logic [chd_pkg::CODE_W-1:0]  code;
   logic [chd_pkg::FIRST_W-1:0] code_ext;
   logic [chd_pkg::FIRST_W-1:0] diff;
   logic [chd_pkg::FIRST_W-1:0] first_sum;
   logic [chd_pkg::IDX_W-1:0]   sym_idx;
   logic                        match;
   logic                        overlong;
   logic                        is_bit;
   logic                        is_end;
   logic                        makes_rsp;
   logic                        req_fire;
   logic                        rsp_fire;
   logic [1:0]                  rsp_status_in;

   // Length register out of range: zero acts as one, above the maximum acts as maximum.
   always_comb begin
      priority if (max_len_ff == '0) begin
         limit = chd_pkg::CFG_W'(1);
      end else if (max_len_ff > chd_pkg::CFG_W'(chd_pkg::MAX_CODE_BITS)) begin
         limit = chd_pkg::CFG_W'(chd_pkg::MAX_CODE_BITS);
      end else begin
         limit = max_len_ff;
      end
   end

   assign len       = taken_ff + chd_pkg::LEN_W'(1);
   assign cnt       = (len <= chd_pkg::LEN_W'(chd_pkg::MAX_CODE_BITS)) ?
                      count_table_ff[len] : '0;
   assign code      = partial_ff | chd_pkg::CODE_W'(req_bus.bit_in);
   assign code_ext  = {1'b0, code};
   assign diff      = code_ext - first_ff;
   assign first_sum = first_ff + chd_pkg::FIRST_W'(cnt);
   assign sym_idx   = base_ff + diff[chd_pkg::IDX_W-1:0];

   // A code below the first code of its length never matches.
   assign match    = (chd_pkg::CFG_W'(len) <= limit) && (code_ext >= first_ff) &&
                     (diff < chd_pkg::FIRST_W'(cnt));
   assign overlong = !match && (chd_pkg::CFG_W'(len) >= limit);

   assign is_bit    = (req_bus.req_type == chd_pkg::REQ_BIT);
   assign is_end    = (req_bus.req_type == chd_pkg::REQ_END);
   assign makes_rsp = is_end || (is_bit && (match || overlong));

   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready || !makes_rsp);
   assign csr_bus.ready = !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_valid_ff && rsp_bus.ready;

   always_comb begin
      partial_in = partial_ff;
      first_in   = first_ff;
      base_in    = base_ff;
      taken_in   = taken_ff;
      if (is_end || (is_bit && (match || overlong))) begin
         partial_in = '0;
         first_in   = '0;
         base_in    = '0;
         taken_in   = '0;
      end else if (is_bit) begin
         partial_in = {code[chd_pkg::CODE_W-2:0], 1'b0};
         first_in   = {first_sum[chd_pkg::FIRST_W-2:0], 1'b0};
         base_in    = base_ff + cnt[chd_pkg::IDX_W-1:0];
         taken_in   = len;
      end
   end

   always_comb begin
      priority if (is_end) begin
         rsp_status_in = (taken_ff == '0) ? chd_pkg::STATUS_CLEAN : chd_pkg::STATUS_LEFTOVER;
      end else if (match) begin
         rsp_status_in = chd_pkg::STATUS_SYMBOL;
      end else begin
         rsp_status_in = chd_pkg::STATUS_OVERLONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= chd_pkg::MAX_LEN_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         max_len_ff <= csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= chd_pkg::MAX_CODE_BITS; i++) begin
            count_table_ff[i] <= '0;
         end
      end else if (req_fire && (req_bus.req_type == chd_pkg::REQ_LOAD_COUNT) &&
                   (req_bus.table_addr <= chd_pkg::ADDR_W'(chd_pkg::MAX_CODE_BITS))) begin
         count_table_ff[req_bus.table_addr[chd_pkg::LEN_W-1:0]] <= req_bus.table_value;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_bus.req_type == chd_pkg::REQ_LOAD_SYMBOL)) begin
         symbol_mem_ff[req_bus.table_addr[chd_pkg::IDX_W-1:0]] <=
            req_bus.table_value[chd_pkg::SYM_W-1:0];
      end
   end

   // The read data holds while a response waits, since only a new response reads.
   always_ff @(posedge clock) begin
      if (req_fire && is_bit && match) begin
         sym_rd_ff <= symbol_mem_ff[sym_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         first_ff   <= '0;
         base_ff    <= '0;
         taken_ff   <= '0;
      end else if (req_fire) begin
         partial_ff <= partial_in;
         first_ff   <= first_in;
         base_ff    <= base_in;
         taken_ff   <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && makes_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && makes_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_is_sym_ff <= is_bit && match;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.symbol = rsp_is_sym_ff ? sym_rd_ff : '0;

endmodule

@@ hw/rtl/chd_checker.sv @@
// Port-level checker for the canonical Huffman bit decoder, bound to its top level.
// Depends on chd_pkg and canonical_huffman_bit_decoder_top.

module chd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [1:0]                req_type,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [chd_pkg::SYM_W-1:0] rsp_symbol,
   input logic [1:0]                rsp_status
);

   logic req_xfer;
   logic end_xfer;

   assign req_xfer = req_valid && req_ready;
   assign end_xfer = req_xfer && (req_type == chd_pkg::REQ_END);

   // Only a decoded symbol carries a nonzero symbol field.
   a_symbol_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != chd_pkg::STATUS_SYMBOL) |-> rsp_symbol == '0)
      else $error("nonzero symbol on a response that is not a decoded symbol");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response stays valid and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_status))
      else $error("response changed or dropped while stalled");

   a_end_responds: assert property (@(posedge clock) disable iff (reset)
      end_xfer |=> rsp_valid && (rsp_status == chd_pkg::STATUS_CLEAN ||
                                 rsp_status == chd_pkg::STATUS_LEFTOVER))
      else $error("end of stream transfer gave no end response");

   // An end right after an end finds no pending code bits.
   a_double_end_clean: assert property (@(posedge clock) disable iff (reset)
      end_xfer ##1 end_xfer |=> rsp_valid && (rsp_status == chd_pkg::STATUS_CLEAN))
      else $error("second end of stream did not report a clean end");

endmodule

bind canonical_huffman_bit_decoder_top chd_checker u_chd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_type   (req_bus.req_type),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_symbol (rsp_bus.symbol),
   .rsp_status (rsp_bus.status)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for canonical_huffman_bit_decoder_top: a short table of directed
// requests, then random code tables, mostly canonical, and bit streams, with bursty traffic.
// Depends on chd_pkg, the channel interfaces in chd_if.sv and the decoder top level.

module tb_top;

   localparam int DIRECTED_ITEMS = 24;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int HOLD_CYCLES    = 250;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_LIMIT    = 5000;
   // About 1600 items, plus the long receiver hold and the idle waits around every
   // register write, then several times over.
   localparam int CYCLE_LIMIT    = 400000;

   typedef struct packed {
      logic [chd_pkg::SYM_W-1:0] symbol;
      chd_pkg::status_code_type  status;
   } outcome_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      chd_pkg::req_code_type      req;
      logic [chd_pkg::ADDR_W-1:0] addr;
      logic [chd_pkg::VAL_W-1:0]  val;
      logic                       code_bit;
      logic                       typed;
      outcome_type                want;
   } row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_type;

   localparam outcome_type NO_WANT       = '{symbol: '0, status: chd_pkg::STATUS_SYMBOL};
   localparam outcome_type CLEAN_END     = '{symbol: '0, status: chd_pkg::STATUS_CLEAN};
   localparam outcome_type LEFTOVER_END  = '{symbol: '0, status: chd_pkg::STATUS_LEFTOVER};
   localparam outcome_type OVERLONG_CODE = '{symbol: '0, status: chd_pkg::STATUS_OVERLONG};

   // Code table used here: one code of length 1 (0), one of length 2 (10) and two of
   // length 3 (110, 111), mapped to symbol entries 0 to 3.
   localparam row_type SCRIPT [0:28] = '{
      '{ROW_REQ, chd_pkg::REQ_END,         8'd0,   9'd0,   1'b0, 1'b1, CLEAN_END},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_END,         8'd0,   9'd0,   1'b0, 1'b1, LEFTOVER_END},
      '{ROW_REQ, chd_pkg::REQ_LOAD_COUNT,  8'd1,   9'd1,   1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_LOAD_COUNT,  8'd2,   9'd1,   1'b1, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_LOAD_COUNT,  8'd3,   9'd2,   1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_LOAD_COUNT,  8'd255, 9'd511, 1'b1, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_LOAD_SYMBOL, 8'd0,   9'd255, 1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_LOAD_SYMBOL, 8'd1,   9'd256, 1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_LOAD_SYMBOL, 8'd2,   9'h05A, 1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_LOAD_SYMBOL, 8'd3,   9'h0A5, 1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd255, 9'd511, 1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b0, NO_WANT},
      '{ROW_CSR, chd_pkg::REQ_END,         8'd0,   9'd2,   1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b1, OVERLONG_CODE},
      '{ROW_CSR, chd_pkg::REQ_END,         8'd0,   9'd0,   1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b1, OVERLONG_CODE},
      '{ROW_CSR, chd_pkg::REQ_END,         8'd0,   9'd16,  1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b1, 1'b0, NO_WANT},
      // Lowering the limit below the bits already taken must end the code at once.
      '{ROW_CSR, chd_pkg::REQ_END,         8'd0,   9'd1,   1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_BIT,         8'd0,   9'd0,   1'b0, 1'b1, OVERLONG_CODE},
      '{ROW_CSR, chd_pkg::REQ_END,         8'd0,   9'd31,  1'b0, 1'b0, NO_WANT},
      '{ROW_REQ, chd_pkg::REQ_END,         8'd0,   9'd0,   1'b0, 1'b1, CLEAN_END}
   };

   logic clock;
   logic reset;

   chd_req_if req_bus ();
   chd_rsp_if rsp_bus ();
   chd_csr_if csr_bus ();

   canonical_huffman_bit_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Mirror of the decoder state.
   logic [chd_pkg::CNT_W-1:0]   count_mem [0:chd_pkg::MAX_CODE_BITS];
   logic [chd_pkg::SYM_W-1:0]   symbol_mem [0:chd_pkg::SYMBOL_COUNT-1];
   logic [chd_pkg::CODE_W-1:0]  code_so_far;
   logic [chd_pkg::FIRST_W-1:0] first_of_len;
   logic [chd_pkg::IDX_W-1:0]   base_of_len;
   int unsigned                 bits_taken;
   logic [chd_pkg::CFG_W-1:0]   max_len;

   outcome_type outcome_q [$];
   int          errors     = 0;
   int          item_count = 0;
   int          burst_left = 0;
   int          cycles     = 0;
   bit          hold_go    = 1'b0;
   bit          hold_done  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void clear_code();
      code_so_far  = '0;
      first_of_len = '0;
      base_of_len  = '0;
      bits_taken   = 0;
   endfunction

   function automatic void add_outcome(input outcome_type o);
      outcome_q.insert(outcome_q.size(), o);
   endfunction

   function automatic void decode_step(input chd_pkg::req_code_type kind,
                                       input logic [chd_pkg::ADDR_W-1:0] addr,
                                       input logic [chd_pkg::VAL_W-1:0] val,
                                       input logic b,
                                       output logic produced,
                                       output outcome_type res);
      int unsigned                 len;
      int unsigned                 limit;
      int unsigned                 offset;
      logic [chd_pkg::CODE_W-1:0]  code;
      logic [chd_pkg::CNT_W-1:0]   cnt;
      logic [chd_pkg::FIRST_W-1:0] sum;
      produced = 1'b0;
      res      = NO_WANT;
      case (kind)
         chd_pkg::REQ_LOAD_COUNT: begin
            if (addr <= chd_pkg::MAX_CODE_BITS)
               count_mem[addr[chd_pkg::LEN_W-1:0]] = val;
         end
         chd_pkg::REQ_LOAD_SYMBOL: begin
            symbol_mem[addr] = val[chd_pkg::SYM_W-1:0];
         end
         chd_pkg::REQ_END: begin
            produced   = 1'b1;
            res.status = (bits_taken == 0) ? chd_pkg::STATUS_CLEAN
                                           : chd_pkg::STATUS_LEFTOVER;
            clear_code();
         end
         default: begin
            len = bits_taken + 1;
            if (max_len == 0) limit = 1;
            else if (max_len > chd_pkg::MAX_CODE_BITS) limit = chd_pkg::MAX_CODE_BITS;
            else limit = max_len;
            code   = code_so_far | chd_pkg::CODE_W'(b);
            cnt    = (len <= chd_pkg::MAX_CODE_BITS) ? count_mem[len] : '0;
            offset = code - first_of_len;
            if (len <= limit && code >= first_of_len && offset < cnt) begin
               produced   = 1'b1;
               res.symbol = symbol_mem[chd_pkg::IDX_W'(base_of_len + offset)];
               res.status = chd_pkg::STATUS_SYMBOL;
               clear_code();
            end else if (len >= limit) begin
               produced   = 1'b1;
               res.status = chd_pkg::STATUS_OVERLONG;
               clear_code();
            end else begin
               // Step to the next length: skip this length's codes and double.
               base_of_len  = chd_pkg::IDX_W'(base_of_len + cnt);
               sum          = first_of_len + cnt;
               first_of_len = {sum[chd_pkg::FIRST_W-2:0], 1'b0};
               code_so_far  = {code[chd_pkg::CODE_W-2:0], 1'b0};
               bits_taken   = len;
            end
         end
      endcase
   endfunction

   task automatic send_req(input chd_pkg::req_code_type kind,
                           input logic [chd_pkg::ADDR_W-1:0] addr,
                           input logic [chd_pkg::VAL_W-1:0] val, input logic b,
                           output logic produced, output outcome_type res);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (hold_go && !hold_done) gap = 0;
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.table_addr  <= addr;
      req_bus.table_value <= val;
      req_bus.bit_in      <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      decode_step(kind, addr, val, b, produced, res);
      item_count++;
   endtask

   task automatic feed(input chd_pkg::req_code_type kind,
                       input logic [chd_pkg::ADDR_W-1:0] addr,
                       input logic [chd_pkg::VAL_W-1:0] val, input logic b);
      logic        produced;
      outcome_type res;
      send_req(kind, addr, val, b, produced, res);
      if (produced) add_outcome(res);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_max_len(input logic [chd_pkg::CFG_W-1:0] v);
      drain();
      // A bit that gives no result may still be settling inside the block.
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      max_len = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(input int p);
      int                          tbl_len;
      int                          cfg_v;
      int                          r;
      int                          l;
      int                          j;
      int                          k;
      int unsigned                 avail;
      int unsigned                 room;
      int unsigned                 total;
      logic [chd_pkg::FIRST_W-1:0] fc;
      logic [chd_pkg::FIRST_W-1:0] sum;
      logic [chd_pkg::CNT_W-1:0]   lc [0:chd_pkg::MAX_CODE_BITS];
      int                          lens_used [$];
      case (p)
         0: begin tbl_len = 16; cfg_v = 16; end
         1: begin tbl_len = 1;  cfg_v = 1;  end
         2: begin tbl_len = 1;  cfg_v = 0;  end
         3: begin tbl_len = 16; cfg_v = 31; end
         default: begin
            tbl_len = $urandom_range(1, chd_pkg::MAX_CODE_BITS);
            cfg_v   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : tbl_len;
         end
      endcase
      set_max_len(chd_pkg::CFG_W'(cfg_v));

      for (l = 0; l <= chd_pkg::MAX_CODE_BITS; l++) lc[l] = '0;
      if (p > 3 && $urandom_range(0, 9) == 0) begin
         // Inconsistent table: counts wrap the code and index arithmetic.
         for (l = 1; l <= chd_pkg::MAX_CODE_BITS; l++)
            lc[l] = chd_pkg::CNT_W'($urandom_range(0, 511));
      end else begin
         avail = 2;
         total = 0;
         for (l = 1; l <= tbl_len; l++) begin
            room = (avail < chd_pkg::SYMBOL_COUNT - total) ? avail
                                                           : chd_pkg::SYMBOL_COUNT - total;
            if (l == tbl_len && $urandom_range(0, 5) != 0) lc[l] = chd_pkg::CNT_W'(room);
            else lc[l] = chd_pkg::CNT_W'($urandom_range(0, (room < 3) ? room : 3));
            total += lc[l];
            avail = (avail - lc[l]) * 2;
            if (avail > (1 << 20)) avail = 1 << 20;
         end
      end

      for (l = 0; l <= chd_pkg::MAX_CODE_BITS; l++)
         feed(chd_pkg::REQ_LOAD_COUNT, chd_pkg::ADDR_W'(l),
              (l == 0) ? chd_pkg::VAL_W'($urandom) : lc[l], 1'($urandom));
      feed(chd_pkg::REQ_LOAD_COUNT,
           chd_pkg::ADDR_W'($urandom_range(chd_pkg::MAX_CODE_BITS + 1, 255)),
           chd_pkg::VAL_W'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 6))
         feed(chd_pkg::REQ_LOAD_SYMBOL, chd_pkg::ADDR_W'($urandom),
              chd_pkg::VAL_W'($urandom), 1'($urandom));

      if (p == 2) hold_go = 1'b1;

      for (l = 1; l <= tbl_len; l++)
         if (lc[l] != 0) lens_used.insert(lens_used.size(), l);

      repeat ($urandom_range(15, 50)) begin
         r = $urandom_range(0, 99);
         if (r < 80 && lens_used.size() != 0) begin
            // Well-formed code: the canonical code of a random entry, MSB first.
            l  = lens_used[$urandom_range(0, lens_used.size() - 1)];
            j  = $urandom_range(0, lc[l] - 1);
            fc = '0;
            for (k = 1; k < l; k++) begin
               sum = fc + lc[k];
               fc  = {sum[chd_pkg::FIRST_W-2:0], 1'b0};
            end
            fc = fc + chd_pkg::FIRST_W'(j);
            for (k = l - 1; k >= 0; k--)
               feed(chd_pkg::REQ_BIT, chd_pkg::ADDR_W'($urandom),
                    chd_pkg::VAL_W'($urandom), fc[k]);
         end else if (r < 88) begin
            feed(chd_pkg::REQ_BIT, chd_pkg::ADDR_W'($urandom),
                 chd_pkg::VAL_W'($urandom), 1'($urandom));
         end else if (r < 92) begin
            feed(chd_pkg::REQ_END, chd_pkg::ADDR_W'($urandom),
                 chd_pkg::VAL_W'($urandom), 1'($urandom));
         end else if (r < 96) begin
            feed(chd_pkg::REQ_LOAD_SYMBOL, chd_pkg::ADDR_W'($urandom),
                 chd_pkg::VAL_W'($urandom), 1'($urandom));
         end else if (r < 98) begin
            feed(chd_pkg::REQ_LOAD_COUNT,
                 chd_pkg::ADDR_W'($urandom_range(chd_pkg::MAX_CODE_BITS + 1, 255)),
                 chd_pkg::VAL_W'($urandom), 1'($urandom));
         end else begin
            feed(chd_pkg::REQ_LOAD_COUNT, '0, chd_pkg::VAL_W'($urandom), 1'($urandom));
         end
      end
      feed(chd_pkg::REQ_END, chd_pkg::ADDR_W'($urandom), chd_pkg::VAL_W'($urandom),
           1'($urandom));
      if ($urandom_range(0, 3) == 0) drain();
   endtask

   // Response side: stall patterns that change now and then, plus one long hold.
   initial begin : rsp_sink
      rx_mode_type rx_mode;
      int          mode_left;
      int          beat;
      rsp_bus.ready = 1'b0;
      rx_mode       = RX_OPEN;
      mode_left     = 0;
      beat          = 0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            beat++;
            case (rx_mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom);
               RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_bus.ready <= (beat % 3 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (outcome_q.size() == 0) begin
            $error("unexpected result: symbol %0d status %0d",
                   rsp_bus.symbol, rsp_bus.status);
            errors++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_bus.symbol !== want.symbol) begin
               $error("symbol: expected %0d, actual %0d", want.symbol, rsp_bus.symbol);
               errors++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      logic        produced;
      outcome_type res;
      int          phase;
      int          waited;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = chd_pkg::REQ_LOAD_COUNT;
      req_bus.table_addr  = '0;
      req_bus.table_value = '0;
      req_bus.bit_in      = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      max_len             = chd_pkg::MAX_LEN_RESET;
      for (int i = 0; i <= chd_pkg::MAX_CODE_BITS; i++) count_mem[i] = '0;
      for (int i = 0; i < chd_pkg::SYMBOL_COUNT; i++) symbol_mem[i] = '0;
      clear_code();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_CSR) begin
            set_max_len(SCRIPT[i].val[chd_pkg::CFG_W-1:0]);
         end else begin
            send_req(SCRIPT[i].req, SCRIPT[i].addr, SCRIPT[i].val, SCRIPT[i].code_bit,
                     produced, res);
            if (SCRIPT[i].typed) add_outcome(SCRIPT[i].want);
            else if (produced) add_outcome(res);
         end
      end

      // Fill every symbol entry so that any index the tables produce is defined.
      for (int i = 0; i < chd_pkg::SYMBOL_COUNT; i++)
         feed(chd_pkg::REQ_LOAD_SYMBOL, chd_pkg::ADDR_W'(i), chd_pkg::VAL_W'($urandom),
              1'($urandom));

      phase = 0;
      while (item_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         run_phase(phase);
         phase++;
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      waited = 0;
      while (outcome_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (outcome_q.size() != 0) begin
         $error("%0d expected results never arrived", outcome_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
